@@ hdl/tmsw_pkg.sv @@
package tmsw_pkg;

    localparam int ADC_W      = 24;
    localparam int LEVEL_W    = 24;
    localparam int ZERO_W     = 24;
    localparam int SPAN_W     = 25;
    localparam int WEIGHT_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN       = 1'b1;

    localparam logic [ZERO_W-1:0] ZERO_LEVEL_RST = 24'd8807000;
    localparam logic [SPAN_W-1:0] SPAN_RST       = 25'd200000;

    // weight arithmetic
    localparam int MG_W     = 18;
    localparam logic signed [MG_W-1:0] MG_PER_100G = 18'sd100000;
    localparam int DIFF_W   = LEVEL_W + 1;
    localparam int PROD_W   = DIFF_W + MG_W;
    localparam int PMAG_W   = 41;
    localparam int QUOT_W   = 32;
    localparam int DVS_W    = SPAN_W;
    localparam int QCNT_W   = $clog2(QUOT_W + 1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic full;
        logic empty;
    } tmsw_qstat_t;

endpackage

@@ hdl/tmsw_queue.sv @@
module tmsw_queue #(
    parameter int DATA_W = 28
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  logic [DATA_W-1:0]         push_data,
    input  logic                      pop,
    output logic [DATA_W-1:0]         pop_data,
    output tmsw_pkg::tmsw_qstat_t     qstat
);
    import tmsw_pkg::*;

    logic [DATA_W-1:0] data_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (cnt_reg == 2'd2);
    assign qstat.empty = (cnt_reg == 2'd0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_data    = data_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

@@ hdl/tmsw_front.sv @@
module tmsw_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int WINDOW_LEN  = 12,
    parameter int SUM_W       = 28
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tmsw_pkg::ADC_W-1:0]  s_adc_code,
    input  tmsw_pkg::tmsw_qstat_t       qstat,
    output logic                        q_push,
    output logic [SUM_W-1:0]            q_data
);
    import tmsw_pkg::*;

    localparam int HIST_LEN = WINDOW_LEN - 1;
    localparam int CNT_W    = $clog2(HIST_LEN);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SCAN = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam logic [SAMPLE_BITS-1:0] TOP_BIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [1:0]             state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SAMPLE_BITS-1:0] win_reg [HIST_LEN];
    logic [SAMPLE_BITS-1:0] cur_reg;
    logic [SAMPLE_BITS-1:0] hi_reg;
    logic [SAMPLE_BITS-1:0] lo_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] cur_next;
    logic [SAMPLE_BITS-1:0] tap;

    assign s_ready  = (state_reg == F_IDLE);
    assign cur_next = SAMPLE_BITS'(s_adc_code) ^ TOP_BIT;
    assign tap      = win_reg[HIST_LEN-1];
    assign q_push   = (state_reg == F_PUSH) && !qstat.full;
    assign q_data   = sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            for (int i = 0; i < HIST_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        cur_reg   <= cur_next;
                        hi_reg    <= cur_next;
                        lo_reg    <= cur_next;
                        sum_reg   <= SUM_W'(cur_next);
                        cnt_reg   <= '0;
                        state_reg <= F_SCAN;
                    end
                end
                F_SCAN: begin
                    // oldest tap is read, window rotates; back in order after HIST_LEN steps
                    if (tap > hi_reg) begin
                        hi_reg <= tap;
                    end
                    if (tap < lo_reg) begin
                        lo_reg <= tap;
                    end
                    sum_reg    <= sum_reg + SUM_W'(tap);
                    win_reg[0] <= tap;
                    for (int i = 1; i < HIST_LEN; i++) begin
                        win_reg[i] <= win_reg[i-1];
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(HIST_LEN - 1)) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!qstat.full) begin
                        win_reg[0] <= cur_reg;
                        for (int i = 1; i < HIST_LEN; i++) begin
                            win_reg[i] <= win_reg[i-1];
                        end
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/tmsw_divider.sv @@
module tmsw_divider #(
    parameter int DIVD_W = 41
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DIVD_W-1:0]             dividend,
    input  logic [tmsw_pkg::DVS_W-1:0]    divisor,
    input  logic [tmsw_pkg::QCNT_W-1:0]   qbits,
    output logic                          busy,
    output logic                          done,
    output logic [tmsw_pkg::QUOT_W-1:0]   quotient
);
    import tmsw_pkg::*;

    // restoring divider, one quotient bit per cycle; caller guarantees
    // dividend >> qbits < divisor so the quotient fits in qbits bits
    logic [DVS_W-1:0]  rem_reg;
    logic [DIVD_W-1:0] num_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    trial_sub;
    logic              fits;

    assign trial     = {rem_reg, num_reg[DIVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = QUOT_W'(num_reg);

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DVS_W'(dividend >> qbits);
            num_reg <= dividend << (DIVD_W - int'(qbits));
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            num_reg <= {num_reg[DIVD_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == QCNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= qbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
                if (cnt_reg == QCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

@@ hdl/tmsw_back.sv @@
module tmsw_back #(
    parameter int WINDOW_LEN  = 12,
    parameter int SUM_W       = 28
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [tmsw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tmsw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  tmsw_pkg::tmsw_qstat_t                qstat,
    output logic                                 q_pop,
    input  logic [SUM_W-1:0]                     q_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tmsw_pkg::LEVEL_W-1:0]         m_filtered_level,
    output logic signed [tmsw_pkg::WEIGHT_W-1:0] m_weight_mg,
    output logic                                 m_span_zero
);
    import tmsw_pkg::*;

    localparam int DIVD_W = PMAG_W;

    // level = sum / (WINDOW_LEN-2) by reciprocal multiply, exact for any sum
    // below 2^SUM_W; the product is built from two halves
    localparam int TRIM_DIV = WINDOW_LEN - 2;
    localparam int RCP_SH   = SUM_W + $clog2(TRIM_DIV);
    localparam int RCP_W    = SUM_W + 1;
    localparam int RCP_LO_W = RCP_W / 2;
    localparam int RCP_HI_W = RCP_W - RCP_LO_W;
    localparam int LOP_W    = SUM_W + RCP_LO_W;
    localparam int LVP_W    = SUM_W + RCP_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << RCP_SH) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV);
    localparam logic [RCP_LO_W-1:0] RCP_LO = RCP_FULL[RCP_LO_W-1:0];
    localparam logic [RCP_HI_W-1:0] RCP_HI = RCP_FULL[RCP_W-1:RCP_LO_W];

    localparam logic [2:0] B_IDLE    = 3'd0;
    localparam logic [2:0] B_LVL     = 3'd1;
    localparam logic [2:0] B_MUL     = 3'd2;
    localparam logic [2:0] B_ABS     = 3'd3;
    localparam logic [2:0] B_W_CHECK = 3'd4;
    localparam logic [2:0] B_W_WAIT  = 3'd5;
    localparam logic [2:0] B_OUT     = 3'd6;

    logic [2:0]               state_reg;
    logic [ZERO_W-1:0]        zero_level_reg;
    logic [SPAN_W-1:0]        span_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [LOP_W-1:0]         lo_prod_reg;
    logic [LEVEL_W-1:0]       level_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PMAG_W-1:0]        pmag_reg;
    logic [DVS_W-1:0]         smag_reg;
    logic                     neg_reg;
    logic                     szero_reg;
    logic [WEIGHT_W-1:0]      wt_reg;

    logic                     m_valid_reg;
    logic [LEVEL_W-1:0]       m_level_reg;
    logic [WEIGHT_W-1:0]      m_weight_reg;
    logic                     m_span_zero_reg;

    logic [LVP_W-1:0]         lvl_prod;
    logic signed [DIFF_W-1:0] diff;
    logic                     out_free;
    logic                     div_start;
    logic [DIVD_W-1:0]        div_dividend;
    logic [DVS_W-1:0]         div_divisor;
    logic [QCNT_W-1:0]        div_qbits;
    logic                     div_busy;
    logic                     div_done;
    logic [QUOT_W-1:0]        div_quot;
    logic                     sat;

    assign lvl_prod = ((LVP_W'(sum_reg) * LVP_W'(RCP_HI)) << RCP_LO_W)
                      + LVP_W'(lo_prod_reg);
    assign diff     = $signed({1'b0, level_reg}) - $signed({1'b0, zero_level_reg});
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == B_IDLE) && !qstat.empty;
    assign sat      = ((pmag_reg >> QUOT_W) >= PMAG_W'(smag_reg));

    assign div_start    = (state_reg == B_W_CHECK) && !szero_reg && !sat;
    assign div_dividend = pmag_reg;
    assign div_divisor  = smag_reg;
    assign div_qbits    = QCNT_W'(QUOT_W);

    assign m_valid          = m_valid_reg;
    assign m_filtered_level = m_level_reg;
    assign m_weight_mg      = $signed(m_weight_reg);
    assign m_span_zero      = m_span_zero_reg;

    tmsw_divider #(
        .DIVD_W (DIVD_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .qbits    (div_qbits),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_level_reg <= ZERO_LEVEL_RST;
            span_reg       <= SPAN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ZERO_LEVEL: zero_level_reg <= cfg_wdata[ZERO_W-1:0];
                REG_SPAN:       span_reg       <= cfg_wdata[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    sum_reg     <= q_data;
                    lo_prod_reg <= LOP_W'(q_data) * LOP_W'(RCP_LO);
                end
            end
            B_LVL: begin
                level_reg <= LEVEL_W'(lvl_prod >> RCP_SH);
            end
            B_MUL: begin
                prod_reg <= PROD_W'(diff * MG_PER_100G);
            end
            B_ABS: begin
                pmag_reg  <= prod_reg[PROD_W-1] ? PMAG_W'(-prod_reg) : PMAG_W'(prod_reg);
                smag_reg  <= span_reg[SPAN_W-1] ? (-span_reg) : span_reg;
                neg_reg   <= prod_reg[PROD_W-1] ^ span_reg[SPAN_W-1];
                szero_reg <= (span_reg == '0);
            end
            B_W_CHECK: begin
                if (szero_reg) begin
                    wt_reg <= '0;
                end else if (sat) begin
                    wt_reg <= neg_reg ? WEIGHT_MIN : WEIGHT_MAX;
                end
            end
            B_W_WAIT: begin
                if (div_done) begin
                    // quotient magnitude from 2^31 up clips to the limit
                    if (neg_reg) begin
                        wt_reg <= div_quot[QUOT_W-1] ? WEIGHT_MIN : WEIGHT_W'(-div_quot);
                    end else begin
                        wt_reg <= div_quot[QUOT_W-1] ? WEIGHT_MAX : WEIGHT_W'(div_quot);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == B_OUT) && out_free) begin
            m_level_reg     <= level_reg;
            m_weight_reg    <= wt_reg;
            m_span_zero_reg <= szero_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == B_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (q_pop) begin
                        state_reg <= B_LVL;
                    end
                end
                B_LVL: begin
                    state_reg <= B_MUL;
                end
                B_MUL: begin
                    state_reg <= B_ABS;
                end
                B_ABS: begin
                    state_reg <= B_W_CHECK;
                end
                B_W_CHECK: begin
                    state_reg <= (szero_reg || sat) ? B_OUT : B_W_WAIT;
                end
                B_W_WAIT: begin
                    if (div_done) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !qstat.empty)
        else $error("pop from empty queue");

    a_zero_span_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_span_zero_reg) |-> (m_weight_reg == '0))
        else $error("zero span beat with nonzero weight");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == B_W_WAIT))
        else $error("divider done outside the wait state");
`endif

endmodule

@@ hdl/trimmed_mean_scale_weigher.sv @@
// Channel  Ports                                        Beat
// -------  -------------------------------------------  ---------------------------
// input    s_valid, s_ready, s_adc_code                 one raw converter code
// result   m_valid, m_ready, m_filtered_level,          one level and weight
//          m_weight_mg, m_span_zero
// config   cfg_wr_en, cfg_index, cfg_wdata              register write, no wait
//
// Front end takes a beat, then walks the WINDOW_LEN-1 stored samples one per
// cycle and pushes the trimmed sum; it takes no new beat until the push is done.
// Back end: reciprocal multiply for the level, built from two halves, then a 32-step
// serial divide for the weight, which sets the rate; the divide is skipped on zero
// span or a clipped weight. A two-entry queue and the result register let each
// side stall on its own. Synchronous active-low reset clears the sample window and
// loads the register defaults; no clearing pass is needed.
module trimmed_mean_scale_weigher #(
    parameter int WINDOW_LEN  = 12,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [tmsw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tmsw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tmsw_pkg::ADC_W-1:0]           s_adc_code,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tmsw_pkg::LEVEL_W-1:0]         m_filtered_level,
    output logic signed [tmsw_pkg::WEIGHT_W-1:0] m_weight_mg,
    output logic                                 m_span_zero
);
    import tmsw_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);

    tmsw_qstat_t      qstat;
    logic             q_push;
    logic [SUM_W-1:0] q_push_data;
    logic             q_pop;
    logic [SUM_W-1:0] q_pop_data;

    tmsw_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_LEN  (WINDOW_LEN),
        .SUM_W       (SUM_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_adc_code (s_adc_code),
        .qstat      (qstat),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    tmsw_queue #(
        .DATA_W (SUM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .qstat     (qstat)
    );

    tmsw_back #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SUM_W       (SUM_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .qstat            (qstat),
        .q_pop            (q_pop),
        .q_data           (q_pop_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_level (m_filtered_level),
        .m_weight_mg      (m_weight_mg),
        .m_span_zero      (m_span_zero)
    );

endmodule
